// ===== rtl/min_heap_priority_queue_unit_defines.svh =====
// Assertion macros shared by the checker of the min-heap priority queue unit.
// No dependencies; included by the checker file.
`ifndef MIN_HEAP_PRIORITY_QUEUE_UNIT_DEFINES_SVH
`define MIN_HEAP_PRIORITY_QUEUE_UNIT_DEFINES_SVH

// Same-cycle implication under synchronous active-low reset.
`define MHPQ_ASSERT_NOW(LBL, CLK, RSTN, ANT, CON, MSG) \
  LBL: assert property (@(posedge CLK) disable iff (!(RSTN)) (ANT) |-> (CON)) \
    else $error(MSG);

// Next-cycle implication under synchronous active-low reset.
`define MHPQ_ASSERT_NEXT(LBL, CLK, RSTN, ANT, CON, MSG) \
  LBL: assert property (@(posedge CLK) disable iff (!(RSTN)) (ANT) |=> (CON)) \
    else $error(MSG);

`endif

// ===== rtl/mhpq_pkg.sv =====
// Package of the min-heap priority queue unit: codes, control word and flag types,
// and the microprogram ROM. No dependencies.
`default_nettype none

package mhpq_pkg;

  localparam int DATA_W   = 32;
  localparam int STATUS_W = 2;
  localparam int OP_W     = 4;
  localparam int COND_W   = 4;
  localparam int PC_W     = 5;

  typedef logic [STATUS_W-1:0] status_t;
  typedef logic [OP_W-1:0]     op_t;
  typedef logic [COND_W-1:0]   cond_t;
  typedef logic [PC_W-1:0]     pc_t;

  localparam status_t ST_OK    = 2'd0;
  localparam status_t ST_EMPTY = 2'd1;
  localparam status_t ST_FULL  = 2'd2;

  localparam logic MODE_INSERT  = 1'b0;
  localparam logic MODE_EXTRACT = 1'b1;

  localparam op_t OP_NONE      = 4'd0;
  localparam op_t OP_LATCH     = 4'd1;
  localparam op_t OP_INS_INIT  = 4'd2;
  localparam op_t OP_RD_PARENT = 4'd3;
  localparam op_t OP_MOVE_UP   = 4'd4;
  localparam op_t OP_WR_KEY    = 4'd5;
  localparam op_t OP_RD_ROOT   = 4'd6;
  localparam op_t OP_TAKE_MIN  = 4'd7;
  localparam op_t OP_LOAD_KEY  = 4'd8;
  localparam op_t OP_RD_LEFT   = 4'd9;
  localparam op_t OP_RD_RIGHT  = 4'd10;
  localparam op_t OP_MOVE_DOWN = 4'd11;
  localparam op_t OP_SET_FULL  = 4'd12;
  localparam op_t OP_SET_EMPTY = 4'd13;
  localparam op_t OP_EMIT      = 4'd14;

  localparam cond_t C_ALWAYS    = 4'd0;
  localparam cond_t C_IN_VALID  = 4'd1;
  localparam cond_t C_MODE_EXT  = 4'd2;
  localparam cond_t C_FULL      = 4'd3;
  localparam cond_t C_EMPTY     = 4'd4;
  localparam cond_t C_AT_ROOT   = 4'd5;
  localparam cond_t C_PARENT_GT = 4'd6;
  localparam cond_t C_NO_LEFT   = 4'd7;
  localparam cond_t C_CHILD_LT  = 4'd8;
  localparam cond_t C_OUT_FREE  = 4'd9;

  localparam pc_t S_IDLE     = 5'd0;
  localparam pc_t S_DISPATCH = 5'd1;
  localparam pc_t S_INS0     = 5'd2;
  localparam pc_t S_INS1     = 5'd3;
  localparam pc_t S_UP0      = 5'd4;
  localparam pc_t S_UP1      = 5'd5;
  localparam pc_t S_PLACE    = 5'd6;
  localparam pc_t S_EXT0     = 5'd7;
  localparam pc_t S_EXT1     = 5'd8;
  localparam pc_t S_EXT2     = 5'd9;
  localparam pc_t S_EXT3     = 5'd10;
  localparam pc_t S_DN0      = 5'd11;
  localparam pc_t S_DN1      = 5'd12;
  localparam pc_t S_DN2      = 5'd13;
  localparam pc_t S_FAILF    = 5'd14;
  localparam pc_t S_FAILE    = 5'd15;
  localparam pc_t S_DONE     = 5'd16;

  typedef struct packed {
    op_t   op;
    cond_t cond;
    pc_t   t_true;
    pc_t   t_false;
  } ctrl_t;

  typedef struct packed {
    logic in_valid;
    logic mode_ext;
    logic full;
    logic empty;
    logic at_root;
    logic parent_gt;
    logic no_left;
    logic child_lt;
    logic out_free;
  } flags_t;

  function automatic ctrl_t cw(op_t op, cond_t cond, pc_t t_true, pc_t t_false);
    ctrl_t w;
    w.op      = op;
    w.cond    = cond;
    w.t_true  = t_true;
    w.t_false = t_false;
    return w;
  endfunction

  function automatic ctrl_t ucode(pc_t pc);
    ctrl_t w;
    case (pc)
      S_IDLE:     w = cw(OP_LATCH,     C_IN_VALID,  S_DISPATCH, S_IDLE);
      S_DISPATCH: w = cw(OP_NONE,      C_MODE_EXT,  S_EXT0,     S_INS0);
      S_INS0:     w = cw(OP_NONE,      C_FULL,      S_FAILF,    S_INS1);
      S_INS1:     w = cw(OP_INS_INIT,  C_ALWAYS,    S_UP0,      S_UP0);
      S_UP0:      w = cw(OP_RD_PARENT, C_AT_ROOT,   S_PLACE,    S_UP1);
      S_UP1:      w = cw(OP_MOVE_UP,   C_PARENT_GT, S_UP0,      S_PLACE);
      S_PLACE:    w = cw(OP_WR_KEY,    C_ALWAYS,    S_DONE,     S_DONE);
      S_EXT0:     w = cw(OP_NONE,      C_EMPTY,     S_FAILE,    S_EXT1);
      S_EXT1:     w = cw(OP_RD_ROOT,   C_ALWAYS,    S_EXT2,     S_EXT2);
      S_EXT2:     w = cw(OP_TAKE_MIN,  C_ALWAYS,    S_EXT3,     S_EXT3);
      S_EXT3:     w = cw(OP_LOAD_KEY,  C_ALWAYS,    S_DN0,      S_DN0);
      S_DN0:      w = cw(OP_RD_LEFT,   C_NO_LEFT,   S_PLACE,    S_DN1);
      S_DN1:      w = cw(OP_RD_RIGHT,  C_ALWAYS,    S_DN2,      S_DN2);
      S_DN2:      w = cw(OP_MOVE_DOWN, C_CHILD_LT,  S_DN0,      S_PLACE);
      S_FAILF:    w = cw(OP_SET_FULL,  C_ALWAYS,    S_DONE,     S_DONE);
      S_FAILE:    w = cw(OP_SET_EMPTY, C_ALWAYS,    S_DONE,     S_DONE);
      S_DONE:     w = cw(OP_EMIT,      C_OUT_FREE,  S_IDLE,     S_DONE);
      default:    w = cw(OP_NONE,      C_ALWAYS,    S_IDLE,     S_IDLE);
    endcase
    return w;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/mhpq_if.sv =====
// Request and result channel interfaces of the min-heap priority queue unit.
// Depends on mhpq_pkg for field widths.
`default_nettype none

interface mhpq_in_if;
  logic                               valid;
  logic                               ready;
  logic                               mode;
  logic signed [mhpq_pkg::DATA_W-1:0] value;

  modport source (output valid, output mode, output value, input ready);
  modport sink   (input valid, input mode, input value, output ready);
endinterface

interface mhpq_out_if;
  logic                               valid;
  logic                               ready;
  logic signed [mhpq_pkg::DATA_W-1:0] min_value;
  mhpq_pkg::status_t                  status;
  logic                               is_empty;

  modport source (output valid, output min_value, output status, output is_empty, input ready);
  modport sink   (input valid, input min_value, input status, input is_empty, output ready);
endinterface

`default_nettype wire

// ===== rtl/mhpq_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none

module mhpq_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

// ===== rtl/mhpq_seq.sv =====
// Microcode sequencer: step counter, control ROM lookup and conditional branch.
// Depends on mhpq_pkg.
`default_nettype none

module mhpq_seq (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire mhpq_pkg::flags_t flags,
  output mhpq_pkg::ctrl_t       ctrl
);

  mhpq_pkg::pc_t pc_r;
  mhpq_pkg::pc_t pc_nxt;
  logic          taken;

  assign ctrl = mhpq_pkg::ucode(pc_r);

  always_comb begin
    case (ctrl.cond)
      mhpq_pkg::C_ALWAYS:    taken = 1'b1;
      mhpq_pkg::C_IN_VALID:  taken = flags.in_valid;
      mhpq_pkg::C_MODE_EXT:  taken = flags.mode_ext;
      mhpq_pkg::C_FULL:      taken = flags.full;
      mhpq_pkg::C_EMPTY:     taken = flags.empty;
      mhpq_pkg::C_AT_ROOT:   taken = flags.at_root;
      mhpq_pkg::C_PARENT_GT: taken = flags.parent_gt;
      mhpq_pkg::C_NO_LEFT:   taken = flags.no_left;
      mhpq_pkg::C_CHILD_LT:  taken = flags.child_lt;
      mhpq_pkg::C_OUT_FREE:  taken = flags.out_free;
      default:               taken = 1'b0;
    endcase
    pc_nxt = taken ? ctrl.t_true : ctrl.t_false;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r <= mhpq_pkg::S_IDLE;
    end else begin
      pc_r <= pc_nxt;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/mhpq_dp.sv =====
// Heap datapath: entry RAM, count, node pointer, moving key and result register.
// Depends on mhpq_pkg and mhpq_ram; driven by mhpq_seq control words.
`default_nettype none

module mhpq_dp #(
  parameter int CAPACITY = 64
) (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  input  wire mhpq_pkg::ctrl_t                    ctrl,
  output mhpq_pkg::flags_t                        flags,
  input  wire logic                               in_valid,
  output logic                                    in_ready,
  input  wire logic                               in_mode,
  input  wire logic signed [mhpq_pkg::DATA_W-1:0] in_value,
  output logic                                    out_valid,
  input  wire logic                               out_ready,
  output logic signed [mhpq_pkg::DATA_W-1:0]      out_min_value,
  output mhpq_pkg::status_t                       out_status,
  output logic                                    out_is_empty
);

  localparam int AW = $clog2(CAPACITY);
  localparam int NW = $clog2(CAPACITY + 1);
  localparam int DW = mhpq_pkg::DATA_W;

  logic [NW-1:0]        count_r, count_nxt;
  logic [NW-1:0]        node_r, node_nxt;
  logic signed [DW-1:0] key_r, key_nxt;
  logic signed [DW-1:0] lval_r, lval_nxt;
  logic signed [DW-1:0] min_r, min_nxt;
  mhpq_pkg::status_t    status_r, status_nxt;
  logic                 mode_r, mode_nxt;
  logic                 out_valid_r, out_valid_nxt;
  logic signed [DW-1:0] out_min_r, out_min_nxt;
  mhpq_pkg::status_t    out_status_r, out_status_nxt;
  logic                 out_empty_r, out_empty_nxt;

  logic                 we;
  logic [AW-1:0]        waddr;
  logic signed [DW-1:0] wdata;
  logic [AW-1:0]        raddr;
  logic [DW-1:0]        ram_rdata;
  logic signed [DW-1:0] rdata;

  logic [NW:0]          node_x2;
  logic [NW-1:0]        node_m1;
  logic [NW-1:0]        parent;
  logic [NW-1:0]        parent_m1;
  logic [NW:0]          left_m1;
  logic [NW:0]          pick_node;
  logic [NW-1:0]        count_m1;
  logic [NW-1:0]        count_p1;
  logic                 right_exists;
  logic                 pick_right;
  logic signed [DW-1:0] pick_val;
  logic                 parent_gt;
  logic                 child_lt;
  logic                 out_free;

  mhpq_ram #(
    .WIDTH (DW),
    .DEPTH (CAPACITY)
  ) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (ram_rdata)
  );

  assign rdata        = ram_rdata;
  assign node_x2      = {node_r, 1'b0};
  assign node_m1      = node_r - NW'(1);
  assign parent       = node_r >> 1;
  assign parent_m1    = parent - NW'(1);
  assign left_m1      = node_x2 - (NW + 1)'(1);
  assign count_m1     = count_r - NW'(1);
  assign count_p1     = count_r + NW'(1);
  assign right_exists = node_x2 < {1'b0, count_r};
  assign pick_right   = right_exists && !(lval_r < rdata);
  assign pick_val     = pick_right ? rdata : lval_r;
  assign pick_node    = pick_right ? (node_x2 + (NW + 1)'(1)) : node_x2;
  assign parent_gt    = rdata > key_r;
  assign child_lt     = pick_val < key_r;
  assign out_free     = !out_valid_r || out_ready;

  assign flags.in_valid  = in_valid;
  assign flags.mode_ext  = (mode_r == mhpq_pkg::MODE_EXTRACT);
  assign flags.full      = (count_r == NW'(CAPACITY));
  assign flags.empty     = (count_r == '0);
  assign flags.at_root   = (node_r == NW'(1));
  assign flags.parent_gt = parent_gt;
  assign flags.no_left   = node_x2 > {1'b0, count_r};
  assign flags.child_lt  = child_lt;
  assign flags.out_free  = out_free;

  assign in_ready = (ctrl.op == mhpq_pkg::OP_LATCH);

  always_comb begin
    count_nxt      = count_r;
    node_nxt       = node_r;
    key_nxt        = key_r;
    lval_nxt       = lval_r;
    min_nxt        = min_r;
    status_nxt     = status_r;
    mode_nxt       = mode_r;
    out_valid_nxt  = out_valid_r && !out_ready;
    out_min_nxt    = out_min_r;
    out_status_nxt = out_status_r;
    out_empty_nxt  = out_empty_r;
    we             = 1'b0;
    waddr          = node_m1[AW-1:0];
    wdata          = key_r;
    raddr          = '0;
    case (ctrl.op)
      mhpq_pkg::OP_LATCH: begin
        if (in_valid) begin
          mode_nxt   = in_mode;
          key_nxt    = in_value;
          status_nxt = mhpq_pkg::ST_OK;
          min_nxt    = '0;
        end
      end
      mhpq_pkg::OP_INS_INIT: begin
        count_nxt = count_p1;
        node_nxt  = count_p1;
      end
      mhpq_pkg::OP_RD_PARENT: begin
        raddr = parent_m1[AW-1:0];
      end
      mhpq_pkg::OP_MOVE_UP: begin
        we    = parent_gt;
        wdata = rdata;
        if (parent_gt) begin
          node_nxt = parent;
        end
      end
      mhpq_pkg::OP_WR_KEY: begin
        we = 1'b1;
      end
      mhpq_pkg::OP_RD_ROOT: begin
        raddr = '0;
      end
      mhpq_pkg::OP_TAKE_MIN: begin
        raddr     = count_m1[AW-1:0];
        min_nxt   = rdata;
        count_nxt = count_m1;
      end
      mhpq_pkg::OP_LOAD_KEY: begin
        key_nxt  = rdata;
        node_nxt = NW'(1);
      end
      mhpq_pkg::OP_RD_LEFT: begin
        raddr = left_m1[AW-1:0];
      end
      mhpq_pkg::OP_RD_RIGHT: begin
        raddr    = node_x2[AW-1:0];
        lval_nxt = rdata;
      end
      mhpq_pkg::OP_MOVE_DOWN: begin
        we    = child_lt;
        wdata = pick_val;
        if (child_lt) begin
          node_nxt = pick_node[NW-1:0];
        end
      end
      mhpq_pkg::OP_SET_FULL: begin
        status_nxt = mhpq_pkg::ST_FULL;
      end
      mhpq_pkg::OP_SET_EMPTY: begin
        status_nxt = mhpq_pkg::ST_EMPTY;
      end
      mhpq_pkg::OP_EMIT: begin
        if (out_free) begin
          out_valid_nxt  = 1'b1;
          out_min_nxt    = min_r;
          out_status_nxt = status_r;
          out_empty_nxt  = (count_r == '0);
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    node_r       <= node_nxt;
    key_r        <= key_nxt;
    lval_r       <= lval_nxt;
    min_r        <= min_nxt;
    status_r     <= status_nxt;
    mode_r       <= mode_nxt;
    out_min_r    <= out_min_nxt;
    out_status_r <= out_status_nxt;
    out_empty_r  <= out_empty_nxt;
  end

  assign out_valid     = out_valid_r;
  assign out_min_value = out_min_r;
  assign out_status    = out_status_r;
  assign out_is_empty  = out_empty_r;

endmodule

`default_nettype wire

// ===== rtl/min_heap_priority_queue_unit.sv =====
// Min-heap priority queue of signed 32-bit values, CAPACITY entries, one request at a
// time. Each request either inserts a value or extracts the minimum, and yields one
// result with the extracted value, a status code and the empty flag. A microcoded
// sequencer walks the heap one level per two steps on sift-up and three on sift-down,
// set by the single read port of the entry RAM and its registered read data. A result
// held by the consumer stalls the next request only once it reaches its result step,
// where the sequencer waits until the result register is free. There is no clearing
// pass after reset. Depends on mhpq_pkg, mhpq_if, mhpq_seq, mhpq_dp.
`default_nettype none

module min_heap_priority_queue_unit #(
  parameter int CAPACITY = 64
) (
  input wire logic   clk,
  input wire logic   rst_n,
  mhpq_in_if.sink    in_ch,
  mhpq_out_if.source out_ch
);

  mhpq_pkg::ctrl_t  ctrl;
  mhpq_pkg::flags_t flags;

  mhpq_seq u_seq (
    .clk   (clk),
    .rst_n (rst_n),
    .flags (flags),
    .ctrl  (ctrl)
  );

  mhpq_dp #(
    .CAPACITY (CAPACITY)
  ) u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .ctrl          (ctrl),
    .flags         (flags),
    .in_valid      (in_ch.valid),
    .in_ready      (in_ch.ready),
    .in_mode       (in_ch.mode),
    .in_value      (in_ch.value),
    .out_valid     (out_ch.valid),
    .out_ready     (out_ch.ready),
    .out_min_value (out_ch.min_value),
    .out_status    (out_ch.status),
    .out_is_empty  (out_ch.is_empty)
  );

endmodule

`default_nettype wire

// ===== rtl/mhpq_checker.sv =====
// Port-level checker of the min-heap priority queue unit, bound to the top level.
// Depends on mhpq_pkg and min_heap_priority_queue_unit_defines.svh.
`default_nettype none
`include "min_heap_priority_queue_unit_defines.svh"

module mhpq_checker (
  input wire logic                               clk,
  input wire logic                               rst_n,
  input wire logic                               in_valid,
  input wire logic                               in_ready,
  input wire logic                               out_valid,
  input wire logic                               out_ready,
  input wire logic signed [mhpq_pkg::DATA_W-1:0] out_min_value,
  input wire mhpq_pkg::status_t                  out_status,
  input wire logic                               out_is_empty
);

  `MHPQ_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(out_min_value) && $stable(out_status) && $stable(out_is_empty), "result changed while stalled")
  `MHPQ_ASSERT_NOW(a_empty_fail, clk, rst_n, out_valid && out_status == mhpq_pkg::ST_EMPTY, out_is_empty && out_min_value == '0, "empty extract reported a value or a non-empty heap")
  `MHPQ_ASSERT_NOW(a_full_fail, clk, rst_n, out_valid && out_status == mhpq_pkg::ST_FULL, !out_is_empty && out_min_value == '0, "full insert reported a value or an empty heap")
  `MHPQ_ASSERT_NEXT(a_busy_after_accept, clk, rst_n, in_valid && in_ready, !in_ready, "request taken while previous one in flight")

endmodule

bind min_heap_priority_queue_unit mhpq_checker u_chk (
  .clk           (clk),
  .rst_n         (rst_n),
  .in_valid      (in_ch.valid),
  .in_ready      (in_ch.ready),
  .out_valid     (out_ch.valid),
  .out_ready     (out_ch.ready),
  .out_min_value (out_ch.min_value),
  .out_status    (out_ch.status),
  .out_is_empty  (out_ch.is_empty)
);

`default_nettype wire

// ===== verif/mhpq_checker.sv =====
// Result checker of the min-heap priority queue unit: mirrors the heap on every
// accepted request and compares each result with the oldest outstanding prediction.
// Depends on mhpq_pkg and the channel interfaces in mhpq_if.
`default_nettype none

module mhpq_scoreboard #(
  parameter int CAPACITY = 64
) (
  input  wire logic clk,
  input  wire logic rst_n,
  mhpq_in_if        in_ch,
  mhpq_out_if       out_ch,
  output int        mismatch_count,
  output int        pending_results
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic signed [mhpq_pkg::DATA_W-1:0] min_value;
    mhpq_pkg::status_t                  status;
    logic                               is_empty;
  } heap_result_t;

  logic signed [mhpq_pkg::DATA_W-1:0] heap_mem [CAPACITY];
  int unsigned              heap_count = 0;
  heap_result_t             result_q [$];
  int                       errors = 0;
  int                       result_idx = 0;

  function automatic void swap_entries(input int unsigned a, input int unsigned b);
    logic signed [mhpq_pkg::DATA_W-1:0] tmp;
    tmp            = heap_mem[a - 1];
    heap_mem[a - 1] = heap_mem[b - 1];
    heap_mem[b - 1] = tmp;
  endfunction

  function automatic heap_result_t heap_apply(input logic mode,
                                              input logic signed [mhpq_pkg::DATA_W-1:0] key);
    heap_result_t r;
    int unsigned  node;
    int unsigned  parent;
    int unsigned  left;
    int unsigned  right;
    int unsigned  pick;
    r.min_value = '0;
    r.status    = mhpq_pkg::ST_OK;
    if (mode == mhpq_pkg::MODE_INSERT) begin
      if (heap_count >= CAPACITY) begin
        r.status = mhpq_pkg::ST_FULL;
      end else begin
        heap_mem[heap_count] = key;
        heap_count++;
        node = heap_count;
        while (node > 1) begin
          parent = node / 2;
          if (heap_mem[parent - 1] > heap_mem[node - 1]) begin
            swap_entries(parent, node);
            node = parent;
          end else begin
            break;
          end
        end
      end
    end else begin
      if (heap_count == 0) begin
        r.status = mhpq_pkg::ST_EMPTY;
      end else begin
        r.min_value = heap_mem[0];
        heap_count--;
        heap_mem[0] = heap_mem[heap_count];
        node = 1;
        while (2 * node <= heap_count) begin
          left  = 2 * node;
          right = left + 1;
          pick  = left;
          if (right <= heap_count && !(heap_mem[left - 1] < heap_mem[right - 1]))
            pick = right;
          if (heap_mem[pick - 1] < heap_mem[node - 1]) begin
            swap_entries(pick, node);
            node = pick;
          end else begin
            break;
          end
        end
      end
    end
    r.is_empty = (heap_count == 0);
    return r;
  endfunction

  always @(posedge clk) begin : monitor
    heap_result_t want;
    heap_result_t got;
    if (!rst_n) begin
      heap_count = 0;
      result_q.delete();
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        got.min_value = out_ch.min_value;
        got.status    = out_ch.status;
        got.is_empty  = out_ch.is_empty;
        if (result_q.size() == 0) begin
          errors++;
          if (errors <= 10)
            $display("%0t: result %0d arrived with no request outstanding", $time,
                     result_idx);
        end else begin
          want = result_q.pop_front();
          if (got.min_value !== want.min_value || got.status !== want.status ||
              got.is_empty !== want.is_empty) begin
            errors++;
            if (errors <= 10)
              $display("%0t: result %0d min_value exp %0d got %0d, status exp %0d got %0d, %s",
                       $time, result_idx, want.min_value, got.min_value, want.status,
                       got.status, $sformatf("is_empty exp %0b got %0b", want.is_empty,
                       got.is_empty));
          end
        end
        result_idx++;
      end
      if (in_ch.valid && in_ch.ready)
        result_q.push_back(heap_apply(in_ch.mode, in_ch.value));
    end
    mismatch_count  <= errors;
    pending_results <= result_q.size();
  end

endmodule

`default_nettype wire

// ===== verif/testbench.sv =====
// Top of the min-heap priority queue unit testbench: clock, reset, request and
// ready stimulus, and the verdict. Depends on mhpq_pkg, mhpq_if, mhpq_checker and the unit.
`default_nettype none

module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int HEAP_CAP = 64;

  logic clk = 1'b0;
  logic rst_n;
  logic calm = 1'b0;
  logic pressure_go = 1'b0;
  int   mismatch_count;
  int   pending_results;

  mhpq_in_if  in_ch ();
  mhpq_out_if out_ch ();

  min_heap_priority_queue_unit #(
    .CAPACITY(HEAP_CAP)
  ) u_dut (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch),
    .out_ch(out_ch)
  );

  mhpq_scoreboard #(
    .CAPACITY(HEAP_CAP)
  ) u_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_ch          (in_ch),
    .out_ch         (out_ch),
    .mismatch_count (mismatch_count),
    .pending_results(pending_results)
  );

  always #6 clk = ~clk;

  function automatic logic signed [mhpq_pkg::DATA_W-1:0] rand_key();
    int pick;
    pick = $urandom_range(99);
    if (pick < 50) return $urandom;
    if (pick < 85) return int'($urandom_range(6)) - 3;
    case ($urandom_range(5))
      0:       return 32'sh8000_0000;
      1:       return 32'sh7fff_ffff;
      2:       return 32'sh8000_0001;
      3:       return 32'sh7fff_fffe;
      4:       return 32'sh0000_0000;
      default: return 32'shffff_ffff;
    endcase
  endfunction

  task automatic send_req(input logic mode, input logic signed [mhpq_pkg::DATA_W-1:0] key);
    while (!calm && $urandom_range(99) < 22) begin
      in_ch.valid <= 1'b0;
      in_ch.mode  <= 1'($urandom_range(1));
      in_ch.value <= $urandom;
      @(negedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.mode  <= mode;
    in_ch.value <= key;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    @(negedge clk);
  endtask

  initial begin : receiver
    int hold_left;
    logic pressure_done;
    hold_left     = 0;
    pressure_done = 1'b0;
    out_ch.ready <= 1'b0;
    forever begin
      @(negedge clk);
      if (hold_left > 0) begin
        out_ch.ready <= 1'b0;
        hold_left--;
      end else if (pressure_go && !pressure_done) begin
        out_ch.ready  <= 1'b0;
        hold_left     = 300;
        pressure_done = 1'b1;
      end else begin
        out_ch.ready <= calm || ($urandom_range(99) >= 22);
      end
    end
  end

  initial begin : stimulus
    int   seg_left;
    int   ins_pct;
    logic mode;
    rst_n       <= 1'b0;
    in_ch.valid <= 1'b0;
    in_ch.mode  <= mhpq_pkg::MODE_INSERT;
    in_ch.value <= '0;
    repeat (5) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    send_req(mhpq_pkg::MODE_EXTRACT, '0);
    send_req(mhpq_pkg::MODE_INSERT, 32'sh0000_0000);
    send_req(mhpq_pkg::MODE_INSERT, 32'sh7fff_ffff);
    send_req(mhpq_pkg::MODE_INSERT, 32'sh8000_0000);
    send_req(mhpq_pkg::MODE_INSERT, 32'shffff_ffff);
    send_req(mhpq_pkg::MODE_INSERT, 32'sd5);
    send_req(mhpq_pkg::MODE_INSERT, 32'sd5);
    send_req(mhpq_pkg::MODE_INSERT, 32'sd5);
    send_req(mhpq_pkg::MODE_INSERT, 32'sd3);
    send_req(mhpq_pkg::MODE_INSERT, 32'sd3);
    repeat (10) send_req(mhpq_pkg::MODE_EXTRACT, $urandom);

    pressure_go = 1'b1;
    repeat (72) send_req(mhpq_pkg::MODE_INSERT, rand_key());
    send_req(mhpq_pkg::MODE_EXTRACT, $urandom);
    send_req(mhpq_pkg::MODE_INSERT, rand_key());
    send_req(mhpq_pkg::MODE_INSERT, rand_key());
    repeat (70) send_req(mhpq_pkg::MODE_EXTRACT, $urandom);

    seg_left = 0;
    ins_pct  = 50;
    for (int i = 0; i < 310; i++) begin
      if (seg_left == 0) begin
        seg_left = $urandom_range(60, 20);
        case ($urandom_range(2))
          0:       ins_pct = 20;
          1:       ins_pct = 50;
          default: ins_pct = 80;
        endcase
      end
      seg_left--;
      calm = (i >= 150 && i < 230);
      mode = ($urandom_range(99) < ins_pct) ? mhpq_pkg::MODE_INSERT : mhpq_pkg::MODE_EXTRACT;
      send_req(mode, (mode == mhpq_pkg::MODE_INSERT) ? rand_key() : $urandom);
    end
    calm = 1'b0;
    in_ch.valid <= 1'b0;

    while (pending_results != 0) @(posedge clk);
    repeat (60) @(posedge clk);
    if (mismatch_count == 0 && pending_results == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  initial begin : watchdog
    #5_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule

`default_nettype wire

// ===== files.f =====
+incdir+rtl
rtl/mhpq_pkg.sv
rtl/mhpq_if.sv
rtl/mhpq_ram.sv
rtl/mhpq_seq.sv
rtl/mhpq_dp.sv
rtl/min_heap_priority_queue_unit.sv
rtl/mhpq_checker.sv
verif/mhpq_checker.sv
verif/testbench.sv
